[src/tlprq_pkg.sv]
// Shared types and constants for the two-level priority request queue.
`default_nettype none

package tlprq_pkg;

	localparam int unsigned DEPTH_DEF = 16;

	localparam logic [7:0]  PRIO_HIGH = 8'd1;
	localparam logic [15:0] ID_FIRST  = 16'd1;
	localparam logic [15:0] ID_MAX    = 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_SUBMIT = 2'd0,
		KIND_POP    = 2'd1,
		KIND_PEEK   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  priority_req;
		logic [15:0] issue_tag;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] entry_id;
		logic        from_high;
		logic [7:0]  entry_priority;
		logic [15:0] entry_tag;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
		logic [15:0] tag;
	} entry_t;

	// Occupancy view of one queue as seen by the arbiter.
	typedef struct packed {
		logic        empty;
		logic        full;
		logic [15:0] next_id;
	} q_stat_t;

endpackage

`default_nettype wire

[src/tlprq_queue.sv]
// One FIFO of the priority queue: entry memory, pointers, count and id counter.
`default_nettype none

module tlprq_queue import tlprq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic [7:0]  push_prio,
	input  wire logic [15:0] push_tag,
	input  wire logic        pop,
	output q_stat_t          stat,
	output entry_t           head_entry
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = AW + 1;

	entry_t          mem [DEPTH];
	entry_t          rd_q;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   tail_q;
	logic [CW-1:0]   count_q;
	logic [15:0]     last_q;

	assign stat.empty   = (count_q == '0);
	assign stat.full    = (count_q == CW'(DEPTH));
	assign stat.next_id = stat.empty ? ID_FIRST :
		((last_q == ID_MAX) ? ID_MAX : last_q + 16'd1);

	assign head_entry = rd_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= '{id: stat.next_id, prio: push_prio, tag: push_tag};
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			last_q  <= '0;
		end else begin
			if (push) begin
				tail_q  <= (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
				last_q  <= stat.next_id;
			end
			if (pop) begin
				head_q  <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count above depth");

endmodule

`default_nettype wire

[src/two_level_priority_request_queue.sv]
// Top level: request register, arbitration over two queues, result register.
//
// Usage:
//   Present a request on req and raise start; it is taken at the clock edge
//   where start is high and busy is low. busy stays low, so one request may
//   be issued every cycle (one request per cycle sustained).
//   Kinds: submit places the request in the high queue (priority 1) or the
//   low queue (any other priority) and returns its new id; pop returns and
//   removes the head of the high queue, or of the low queue when the high
//   queue is empty; peek returns the same entry without removing it.
//   Every request yields exactly one result on rsp, marked by done for one
//   cycle. It passes the request register, where the decision is made and
//   the queue memory is read, and then the result register, fed by the
//   registered memory read.
//   Results come out in request order. The receiver cannot stall; done is
//   a strobe and the result must be taken in that cycle.
//   Reset (arst_n low) empties both queues, clears the id counters and
//   drops any request in flight. Queue memories are not cleared.
`default_nettype none

module two_level_priority_request_queue import tlprq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  req_t      req,
	output logic      done,
	output rsp_t      rsp
);

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_ECHO,
		SEL_HIGH,
		SEL_LOW
	} sel_t;

	logic    valid_s1;
	req_t    req_s1;

	logic    valid_s2;
	status_t status_s2;
	logic    from_high_s2;
	sel_t    sel_s2;
	entry_t  echo_s2;

	q_stat_t hi_stat;
	q_stat_t lo_stat;
	entry_t  hi_head;
	entry_t  lo_head;

	logic    push_hi;
	logic    push_lo;
	logic    pop_hi;
	logic    pop_lo;
	logic    is_hi;
	status_t status_d;
	logic    from_high_d;
	sel_t    sel_d;
	entry_t  echo_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	always_comb begin
		is_hi       = (req_s1.priority_req == PRIO_HIGH);
		push_hi     = 1'b0;
		push_lo     = 1'b0;
		pop_hi      = 1'b0;
		pop_lo      = 1'b0;
		status_d    = ST_OK;
		from_high_d = 1'b0;
		sel_d       = SEL_ZERO;
		echo_d      = '{id: is_hi ? hi_stat.next_id : lo_stat.next_id,
			prio: req_s1.priority_req, tag: req_s1.issue_tag};
		if (valid_s1) begin
			unique case (req_s1.kind)
				KIND_SUBMIT: begin
					from_high_d = is_hi;
					if (is_hi ? hi_stat.full : lo_stat.full) begin
						status_d = ST_FULL;
					end else begin
						sel_d   = SEL_ECHO;
						push_hi = is_hi;
						push_lo = !is_hi;
					end
				end
				KIND_POP, KIND_PEEK: begin
					if (!hi_stat.empty) begin
						sel_d       = SEL_HIGH;
						from_high_d = 1'b1;
						pop_hi      = (req_s1.kind == KIND_POP);
					end else if (!lo_stat.empty) begin
						sel_d  = SEL_LOW;
						pop_lo = (req_s1.kind == KIND_POP);
					end else begin
						status_d = ST_EMPTY;
					end
				end
				default: begin
					// unused kind: answer ok with an all-zero entry
					status_d = ST_OK;
				end
			endcase
		end
	end

	tlprq_queue #(.DEPTH(DEPTH)) u_high (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_hi),
		.push_prio  (req_s1.priority_req),
		.push_tag   (req_s1.issue_tag),
		.pop        (pop_hi),
		.stat       (hi_stat),
		.head_entry (hi_head)
	);

	tlprq_queue #(.DEPTH(DEPTH)) u_low (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_lo),
		.push_prio  (req_s1.priority_req),
		.push_tag   (req_s1.issue_tag),
		.pop        (pop_lo),
		.stat       (lo_stat),
		.head_entry (lo_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		status_s2    <= status_d;
		from_high_s2 <= from_high_d;
		sel_s2       <= sel_d;
		echo_s2      <= echo_d;
	end

	// head entries arrive from the registered memory reads in this cycle
	always_comb begin
		rsp.status    = status_s2;
		rsp.from_high = from_high_s2;
		case (sel_s2)
			SEL_ECHO: begin
				rsp.entry_id       = echo_s2.id;
				rsp.entry_priority = echo_s2.prio;
				rsp.entry_tag      = echo_s2.tag;
			end
			SEL_HIGH: begin
				rsp.entry_id       = hi_head.id;
				rsp.entry_priority = hi_head.prio;
				rsp.entry_tag      = hi_head.tag;
			end
			SEL_LOW: begin
				rsp.entry_id       = lo_head.id;
				rsp.entry_priority = lo_head.prio;
				rsp.entry_tag      = lo_head.tag;
			end
			default: begin
				rsp.entry_id       = '0;
				rsp.entry_priority = '0;
				rsp.entry_tag      = '0;
			end
		endcase
	end

	assign done = valid_s2;

	a_done_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1)) else $error("result without request");
	a_one_push: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_hi && push_lo) && !(pop_hi && pop_lo) && !((push_hi || push_lo) &&
		(pop_hi || pop_lo))) else $error("more than one queue update");
	a_low_pop_only_hi_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_lo |-> hi_stat.empty) else $error("low queue served ahead of high");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_EMPTY) |-> (rsp.entry_id == '0 && !rsp.from_high))
		else $error("empty result carries an entry");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the two-level priority request queue.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tlprq_pkg::*;

	localparam int unsigned QDEPTH        = DEPTH_DEF;
	localparam int unsigned RANDOM_ITEMS  = 1900;
	localparam int unsigned STALL_LIMIT   = 1000;
	localparam int unsigned MAX_REPORTS   = 100;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned MAX_GAP       = 11;
	localparam kind_t       KIND_UNUSED   = kind_t'(2'd3);
	localparam bit          SEL_HIGH      = 1'b1;
	localparam bit          SEL_LOW       = 1'b0;

	typedef struct packed {
		req_t r;
		logic typed;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	// queue state as the predictor sees it; index 1 is the high queue
	entry_t      q_mem [2][QDEPTH];
	int unsigned q_head [2];
	int unsigned q_count [2];
	logic [15:0] q_last [2];

	rsp_t        expected_rsp [$];
	dir_row_t    dir_rows [$];
	int unsigned mismatches;
	int unsigned stall_cycles;

	two_level_priority_request_queue #(.DEPTH(QDEPTH)) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always #5 clk = ~clk;

	function automatic req_t make_req(kind_t k, logic [7:0] p, logic [15:0] t);
		req_t r;
		r.kind = k;
		r.priority_req = p;
		r.issue_tag = t;
		return r;
	endfunction

	function automatic rsp_t make_rsp(status_t s, logic [15:0] id, logic hi,
			logic [7:0] p, logic [15:0] t);
		rsp_t o;
		o.status = s;
		o.entry_id = id;
		o.from_high = hi;
		o.entry_priority = p;
		o.entry_tag = t;
		return o;
	endfunction

	function automatic void add_row(req_t r, logic typed, rsp_t want);
		dir_row_t row;
		row.r = r;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	// Advance the queue state by one request and return its result.
	function automatic rsp_t predict_response(req_t r);
		rsp_t        o;
		bit          sel;
		int unsigned slot;
		logic [15:0] nid;
		entry_t      e;
		o = make_rsp(ST_OK, 16'd0, 1'b0, 8'd0, 16'd0);
		case (r.kind)
			KIND_SUBMIT: begin
				sel = (r.priority_req == PRIO_HIGH);
				o.from_high = sel;
				if (q_count[sel] >= QDEPTH) begin
					o.status = ST_FULL;
				end else begin
					if (q_count[sel] == 0)
						nid = ID_FIRST;
					else if (q_last[sel] == ID_MAX)
						nid = ID_MAX;
					else
						nid = q_last[sel] + 16'd1;
					slot = (q_head[sel] + q_count[sel]) % QDEPTH;
					e.id = nid;
					e.prio = r.priority_req;
					e.tag = r.issue_tag;
					q_mem[sel][slot] = e;
					q_count[sel] = q_count[sel] + 1;
					q_last[sel] = nid;
					o.entry_id = nid;
					o.entry_priority = r.priority_req;
					o.entry_tag = r.issue_tag;
				end
			end
			KIND_POP, KIND_PEEK: begin
				if (q_count[SEL_HIGH] == 0 && q_count[SEL_LOW] == 0) begin
					o.status = ST_EMPTY;
				end else begin
					sel = (q_count[SEL_HIGH] != 0);
					e = q_mem[sel][q_head[sel]];
					if (r.kind == KIND_POP) begin
						q_head[sel] = (q_head[sel] + 1) % QDEPTH;
						q_count[sel] = q_count[sel] - 1;
					end
					o.entry_id = e.id;
					o.from_high = sel;
					o.entry_priority = e.prio;
					o.entry_tag = e.tag;
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// Hold start low for the gap, present the request, wait for it to be taken.
	task automatic issue_request(req_t r, int unsigned gap, logic typed, rsp_t want);
		rsp_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		predicted = predict_response(r);
		expected_rsp.push_back(typed ? want : predicted);
	endtask

	task automatic issue_checked(req_t r, int unsigned gap);
		issue_request(r, gap, 1'b0, '0);
	endtask

	// Compare each strobed result with the oldest expectation.
	always @(negedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < MAX_REPORTS)
					$display("%0t: unexpected result, actual %p", $time, rsp);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status || rsp.entry_id !== want.entry_id ||
						rsp.from_high !== want.from_high ||
						rsp.entry_priority !== want.entry_priority ||
						rsp.entry_tag !== want.entry_tag) begin
					mismatches <= mismatches + 1;
					if (mismatches < MAX_REPORTS)
						$display("%0t: result mismatch, expected %p, actual %p",
							$time, want, rsp);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("two_level_priority_request_queue test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int unsigned sent;
		int unsigned burst_len;
		int unsigned submit_pct;
		int unsigned high_pct;
		int unsigned roll;
		int unsigned gap;
		bit          fast;
		kind_t       k;
		logic [7:0]  prio;
		logic [15:0] tag;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		mismatches = 0;
		stall_cycles = 0;
		for (int q = 0; q < 2; q++) begin
			q_head[q] = 0;
			q_count[q] = 0;
			q_last[q] = 16'd0;
		end

		// empty queues, unused kind, field extremes, high-over-low order
		add_row(make_req(KIND_POP, 8'd0, 16'd0), 1'b1,
			make_rsp(ST_EMPTY, 16'd0, 1'b0, 8'd0, 16'd0));
		add_row(make_req(KIND_PEEK, 8'hFF, 16'hFFFF), 1'b1,
			make_rsp(ST_EMPTY, 16'd0, 1'b0, 8'd0, 16'd0));
		add_row(make_req(KIND_UNUSED, 8'hFF, 16'hFFFF), 1'b1,
			make_rsp(ST_OK, 16'd0, 1'b0, 8'd0, 16'd0));
		add_row(make_req(KIND_SUBMIT, PRIO_HIGH, 16'hFFFF), 1'b1,
			make_rsp(ST_OK, ID_FIRST, 1'b1, PRIO_HIGH, 16'hFFFF));
		add_row(make_req(KIND_SUBMIT, 8'd0, 16'd0), 1'b1,
			make_rsp(ST_OK, ID_FIRST, 1'b0, 8'd0, 16'd0));
		add_row(make_req(KIND_SUBMIT, 8'hFF, 16'h5A5A), 1'b1,
			make_rsp(ST_OK, 16'd2, 1'b0, 8'hFF, 16'h5A5A));
		add_row(make_req(KIND_SUBMIT, PRIO_HIGH, 16'hA5A5), 1'b0, '0);
		add_row(make_req(KIND_SUBMIT, 8'd2, 16'h0001), 1'b0, '0);
		add_row(make_req(KIND_PEEK, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_req(KIND_UNUSED, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_req(KIND_POP, 8'hFF, 16'hFFFF), 1'b0, '0);
		add_row(make_req(KIND_PEEK, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_req(KIND_POP, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_req(KIND_POP, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_req(KIND_PEEK, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_req(KIND_POP, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_req(KIND_POP, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_req(KIND_POP, 8'd0, 16'd0), 1'b1,
			make_rsp(ST_EMPTY, 16'd0, 1'b0, 8'd0, 16'd0));
		add_row(make_req(KIND_SUBMIT, 8'h80, 16'h1234), 1'b1,
			make_rsp(ST_OK, ID_FIRST, 1'b0, 8'h80, 16'h1234));
		add_row(make_req(KIND_SUBMIT, PRIO_HIGH, 16'h8000), 1'b1,
			make_rsp(ST_OK, ID_FIRST, 1'b1, PRIO_HIGH, 16'h8000));
		add_row(make_req(KIND_PEEK, 8'd0, 16'd0), 1'b0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			issue_request(dir_rows[i].r, $urandom_range(0, MAX_GAP),
				dir_rows[i].typed, dir_rows[i].want);

		// drain both queues before the random part
		while (q_count[SEL_HIGH] + q_count[SEL_LOW] != 0)
			issue_checked(make_req(KIND_POP, 8'd0, 16'd0), $urandom_range(0, 1));

		// bursts that lean toward filling or draining one or both queues
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst_len = $urandom_range(10, 60);
			case ($urandom_range(0, 2))
				0: submit_pct = 90;
				1: submit_pct = 50;
				default: submit_pct = 15;
			endcase
			case ($urandom_range(0, 2))
				0: high_pct = 100;
				1: high_pct = 50;
				default: high_pct = 0;
			endcase
			fast = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < burst_len; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 2)
					k = KIND_UNUSED;
				else if (roll < submit_pct)
					k = KIND_SUBMIT;
				else if ($urandom_range(0, 2) == 0)
					k = KIND_PEEK;
				else
					k = KIND_POP;
				if ($urandom_range(0, 99) < high_pct)
					prio = PRIO_HIGH;
				else
					prio = 8'($urandom_range(0, 255));
				tag = 16'($urandom);
				gap = fast ? 0 : $urandom_range(0, MAX_GAP);
				issue_checked(make_req(k, prio, tag), gap);
				sent++;
			end
		end

		start <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("two_level_priority_request_queue test passed");
		else
			$display("two_level_priority_request_queue test failed");
		$finish;
	end

endmodule
